FILE: rtl/sle_pkg.sv
// Package for the string literal unescaper: result codes, byte constants,
// counter width and counter helpers. No dependencies.
package sle_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int EXT_WIDTH   = ((COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH) + 1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [2:0]             kind_t;

    localparam kind_t KIND_NONE    = 3'd0;
    localparam kind_t KIND_STORED  = 3'd1;
    localparam kind_t KIND_DROPPED = 3'd2;
    localparam kind_t KIND_ENDED   = 3'd3;
    localparam kind_t KIND_FAILED  = 3'd4;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_R       = 8'h72;

    localparam logic [15:0] CAPACITY_RESET = 16'd256;
    localparam count_t      COUNT_MAX      = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_char;
        logic [15:0] end_position;
        logic [15:0] stored_count;
    } result_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == COUNT_MAX) ? COUNT_MAX : v + count_t'(1);
        return r;
    endfunction

    // counter value as reported on a 16-bit field
    function automatic logic [15:0] to_out(input count_t v);
        logic [EXT_WIDTH-1:0] e;
        e = EXT_WIDTH'(v);
        return e[15:0];
    endfunction

endpackage

FILE: rtl/sle_src_if.sv
// Source byte channel: valid/ready handshake carrying one source byte word.
// Depends on nothing.
interface sle_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       start_req;

    modport source (output valid, output src_byte, output start_req, input ready);
    modport sink   (input valid, input src_byte, input start_req, output ready);
endinterface

FILE: rtl/sle_res_if.sv
// Result channel: valid/ready handshake carrying one decoded result word.
// Depends on nothing.
interface sle_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_char;
    logic [15:0] end_position;
    logic [15:0] stored_count;

    modport source (output valid, output kind, output out_char, output end_position,
                    output stored_count, input ready);
    modport sink   (input valid, input kind, input out_char, input end_position,
                    input stored_count, output ready);
endinterface

FILE: rtl/sle_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying dst_capacity.
// Depends on nothing.
interface sle_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] dst_capacity;

    modport source (output valid, output dst_capacity, input ready);
    modport sink   (input valid, input dst_capacity, output ready);
endinterface

FILE: rtl/sle_core.sv
// Per-byte decode and literal state (active, escape, quote, position, count).
// Depends on sle_pkg.
module sle_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       src_byte,
    input  logic             start_req,
    input  logic [15:0]      dst_capacity,
    output sle_pkg::result_t res
);

    logic            active_reg,    active_next;
    logic            escape_reg,    escape_next;
    logic            dquote_reg,    dquote_next;
    sle_pkg::count_t position_reg,  position_next;
    sle_pkg::count_t count_reg,     count_next;

    logic                          is_ctrl;
    logic [7:0]                    quote_char;
    logic [7:0]                    dec_char;
    logic [sle_pkg::EXT_WIDTH-1:0] count_plus;
    logic [sle_pkg::EXT_WIDTH-1:0] cap_ext;
    sle_pkg::count_t               pos_inc;
    sle_pkg::count_t               cnt_inc;

    always_comb
    begin
        is_ctrl    = (src_byte < sle_pkg::CTRL_LIMIT) && (src_byte != sle_pkg::CH_TAB);
        quote_char = dquote_reg ? sle_pkg::CH_DQUOTE : sle_pkg::CH_SQUOTE;
        count_plus = sle_pkg::EXT_WIDTH'(count_reg) + sle_pkg::EXT_WIDTH'(1);
        cap_ext    = sle_pkg::EXT_WIDTH'(dst_capacity);
        pos_inc    = sle_pkg::sat_inc(position_reg);
        cnt_inc    = sle_pkg::sat_inc(count_reg);

        case (src_byte)
            sle_pkg::CH_N: dec_char = sle_pkg::CH_LF;
            sle_pkg::CH_T: dec_char = sle_pkg::CH_TAB;
            sle_pkg::CH_R: dec_char = sle_pkg::CH_CR;
            default:       dec_char = src_byte;
        endcase
        if (!escape_reg)
        begin
            dec_char = src_byte;
        end

        active_next   = active_reg;
        escape_next   = escape_reg;
        dquote_next   = dquote_reg;
        position_next = position_reg;
        count_next    = count_reg;

        res.kind         = sle_pkg::KIND_NONE;
        res.out_char     = 8'd0;
        res.end_position = 16'd0;
        res.stored_count = sle_pkg::to_out(count_reg);

        if (start_req)
        begin
            escape_next      = 1'b0;
            count_next       = '0;
            res.stored_count = 16'd0;
            if ((src_byte == sle_pkg::CH_SQUOTE) || (src_byte == sle_pkg::CH_DQUOTE))
            begin
                active_next   = 1'b1;
                dquote_next   = (src_byte == sle_pkg::CH_DQUOTE);
                position_next = sle_pkg::count_t'(1);
            end
            else
            begin
                active_next   = 1'b0;
                position_next = '0;
                res.kind      = sle_pkg::KIND_FAILED;
            end
        end
        else if (!active_reg)
        begin
            // idle byte: report count of the last literal
        end
        else if (is_ctrl)
        begin
            // control bytes fail even when escaped
            active_next = 1'b0;
            escape_next = 1'b0;
            res.kind    = sle_pkg::KIND_FAILED;
        end
        else if (!escape_reg && (src_byte == quote_char))
        begin
            active_next      = 1'b0;
            position_next    = pos_inc;
            res.kind         = sle_pkg::KIND_ENDED;
            res.end_position = sle_pkg::to_out(pos_inc);
        end
        else if (!escape_reg && (src_byte == sle_pkg::CH_BSLASH))
        begin
            escape_next   = 1'b1;
            position_next = pos_inc;
        end
        else
        begin
            escape_next   = 1'b0;
            position_next = pos_inc;
            if (count_plus < cap_ext)
            begin
                count_next       = cnt_inc;
                res.kind         = sle_pkg::KIND_STORED;
                res.out_char     = dec_char;
                res.stored_count = sle_pkg::to_out(cnt_inc);
            end
            else
            begin
                res.kind = sle_pkg::KIND_DROPPED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            escape_reg   <= 1'b0;
            dquote_reg   <= 1'b0;
            position_reg <= '0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            active_reg   <= active_next;
            escape_reg   <= escape_next;
            dquote_reg   <= dquote_next;
            position_reg <= position_next;
            count_reg    <= count_next;
        end
    end

endmodule

FILE: rtl/string_literal_unescaper.sv
// Top level of the string literal unescaper: input register, decode core,
// result register and capacity register. Depends on sle_pkg, the channel
// interfaces and sle_core.

// One source byte word per cycle in, one result word per byte out. A byte is
// captured in the input register, decoded against the literal state in a
// single pass and written to the result register, from which its result word
// is presented; a result stall can hold the byte in the input register. While a
// result word waits, the input register takes one more byte and then holds the
// input off; full rate is held for as long as the result sink takes a word
// every cycle. The capacity register resets to 256 and may be written only
// while no byte is in flight.
module string_literal_unescaper
(
    input  logic     clk,
    input  logic     rst_n,
    sle_src_if.sink  src,
    sle_res_if.source result,
    sle_cfg_if.sink  cfg
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_start_reg;
    logic             out_valid_reg;
    sle_pkg::result_t out_reg;
    logic [15:0]      capacity_reg;

    sle_pkg::result_t core_res;
    logic             advance;

    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign src.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    sle_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .src_byte     (in_byte_reg),
        .start_req    (in_start_reg),
        .dst_capacity (capacity_reg),
        .res          (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= sle_pkg::CAPACITY_RESET;
        end
        else
        begin
            if (src.ready)
            begin
                in_valid_reg <= src.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                capacity_reg <= cfg.dst_capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            in_byte_reg  <= src.src_byte;
            in_start_reg <= src.start_req;
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_reg.kind;
    assign result.out_char     = out_reg.out_char;
    assign result.end_position = out_reg.end_position;
    assign result.stored_count = out_reg.stored_count;

endmodule

FILE: tb/string_literal_unescaper_checker.sv
`timescale 1ns / 100ps
// Checker for string_literal_unescaper: watches the source, result and capacity
// channels, decodes every accepted byte on its own and compares each result word.
// Depends on sle_pkg and the sle_src_if, sle_res_if and sle_cfg_if interfaces.
module string_literal_unescaper_checker
(
    input  logic clk,
    input  logic rst_n,
    sle_src_if   src,
    sle_res_if   result,
    sle_cfg_if   cfg,
    output int   fail_count,
    output int   pending,
    output int   stored_seen,
    output int   dropped_seen,
    output int   ended_seen,
    output int   failed_seen
);

    // decoder state as the block should hold it
    logic [15:0]      capacity     = sle_pkg::CAPACITY_RESET;
    logic             in_literal   = 1'b0;
    logic             escape_next  = 1'b0;
    logic             double_quote = 1'b0;
    sle_pkg::count_t  position     = '0;
    sle_pkg::count_t  char_total   = '0;

    sle_pkg::result_t decoded_words[$];
    sle_pkg::result_t want;
    int               errors   = 0;
    int               n_stored = 0;
    int               n_dropped = 0;
    int               n_ended  = 0;
    int               n_failed = 0;

    function automatic sle_pkg::count_t bump(input sle_pkg::count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // advances the literal state by one byte and returns the word it causes
    function automatic sle_pkg::result_t decode_byte(input logic [7:0] b, input logic start);
        sle_pkg::result_t r;
        logic [7:0]       quote_ch;
        logic [7:0]       ch;
        r = '0;
        if (start)
        begin
            escape_next = 1'b0;
            char_total  = '0;
            if (b == sle_pkg::CH_SQUOTE || b == sle_pkg::CH_DQUOTE)
            begin
                in_literal   = 1'b1;
                double_quote = (b == sle_pkg::CH_DQUOTE);
                position     = sle_pkg::count_t'(1);
                r.kind       = sle_pkg::KIND_NONE;
            end
            else
            begin
                in_literal = 1'b0;
                position   = '0;
                r.kind     = sle_pkg::KIND_FAILED;
            end
            return r;
        end
        r.stored_count = 16'(char_total);
        r.kind         = sle_pkg::KIND_NONE;
        if (!in_literal)
        begin
            return r;
        end
        // control bytes kill the literal even right after a backslash
        if (b < sle_pkg::CTRL_LIMIT && b != sle_pkg::CH_TAB)
        begin
            in_literal  = 1'b0;
            escape_next = 1'b0;
            r.kind      = sle_pkg::KIND_FAILED;
            return r;
        end
        quote_ch = double_quote ? sle_pkg::CH_DQUOTE : sle_pkg::CH_SQUOTE;
        if (escape_next)
        begin
            escape_next = 1'b0;
            case (b)
                sle_pkg::CH_N: ch = sle_pkg::CH_LF;
                sle_pkg::CH_T: ch = sle_pkg::CH_TAB;
                sle_pkg::CH_R: ch = sle_pkg::CH_CR;
                default:       ch = b;
            endcase
        end
        else if (b == quote_ch)
        begin
            in_literal     = 1'b0;
            position       = bump(position);
            r.kind         = sle_pkg::KIND_ENDED;
            r.end_position = 16'(position);
            return r;
        end
        else if (b == sle_pkg::CH_BSLASH)
        begin
            escape_next = 1'b1;
            position    = bump(position);
            return r;
        end
        else
        begin
            ch = b;
        end
        position = bump(position);
        if (longint'(char_total) + 1 < longint'(capacity))
        begin
            char_total     = bump(char_total);
            r.kind         = sle_pkg::KIND_STORED;
            r.out_char     = ch;
            r.stored_count = 16'(char_total);
        end
        else
        begin
            r.kind = sle_pkg::KIND_DROPPED;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity     = sle_pkg::CAPACITY_RESET;
            in_literal   = 1'b0;
            escape_next  = 1'b0;
            double_quote = 1'b0;
            position     = '0;
            char_total   = '0;
            decoded_words.delete();
            pending     <= 0;
        end
        else
        begin
            // a word leaving now always belongs to a byte taken at an earlier edge
            if (result.valid && result.ready)
            begin
                if (decoded_words.size() == 0)
                begin
                    errors++;
                    $error("result word with no byte waiting: kind %0d", result.kind);
                end
                else
                begin
                    want = decoded_words.pop_front();
                    check_field("kind", 16'(want.kind), 16'(result.kind));
                    check_field("out_char", 16'(want.out_char), 16'(result.out_char));
                    check_field("end_position", want.end_position, result.end_position);
                    check_field("stored_count", want.stored_count, result.stored_count);
                    case (result.kind)
                        sle_pkg::KIND_STORED:  n_stored++;
                        sle_pkg::KIND_DROPPED: n_dropped++;
                        sle_pkg::KIND_ENDED:   n_ended++;
                        sle_pkg::KIND_FAILED:  n_failed++;
                        default:               ;
                    endcase
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                capacity = cfg.dst_capacity;
            end
            if (src.valid && src.ready)
            begin
                decoded_words.push_back(decode_byte(src.src_byte, src.start_req));
            end
            pending <= decoded_words.size();
        end
    end

    always @(posedge clk)
    begin
        fail_count   <= errors;
        stored_seen  <= n_stored;
        dropped_seen <= n_dropped;
        ended_seen   <= n_ended;
        failed_seen  <= n_failed;
    end

endmodule

FILE: tb/string_literal_unescaper_tb.sv
`timescale 1ns / 100ps
// Top of the string_literal_unescaper testbench: clock, reset, byte and capacity
// stimulus, result back-pressure and the verdict. Depends on sle_pkg, the channel
// interfaces, the block and string_literal_unescaper_checker.
module string_literal_unescaper_tb;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_LEN    = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sle_src_if src_ch();
    sle_res_if res_ch();
    sle_cfg_if cfg_ch();

    int fail_count;
    int pending;
    int stored_seen;
    int dropped_seen;
    int ended_seen;
    int failed_seen;

    int bytes_sent  = 0;
    int cap_writes  = 0;
    int cycle_count = 0;
    int hold_token  = 0;
    bit gaps_on     = 1'b1;

    always #HALF_PERIOD clk = ~clk;

    string_literal_unescaper DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    string_literal_unescaper_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .src          (src_ch),
        .result       (res_ch),
        .cfg          (cfg_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .stored_seen  (stored_seen),
        .dropped_seen (dropped_seen),
        .ended_seen   (ended_seen),
        .failed_seen  (failed_seen)
    );

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] other_quote(input logic [7:0] q);
        return (q == sle_pkg::CH_DQUOTE) ? sle_pkg::CH_SQUOTE : sle_pkg::CH_DQUOTE;
    endfunction

    function automatic logic [7:0] plain_char(input logic [7:0] q);
        logic [7:0] c;
        c = 8'($urandom_range(32, 255));
        while (c == q || c == sle_pkg::CH_BSLASH)
        begin
            c = 8'($urandom_range(32, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] escape_target(input logic [7:0] q);
        case ($urandom_range(0, 6))
            0:       return sle_pkg::CH_N;
            1:       return sle_pkg::CH_T;
            2:       return sle_pkg::CH_R;
            3:       return q;
            4:       return sle_pkg::CH_BSLASH;
            5:       return other_quote(q);
            default: return 8'($urandom_range(32, 255));
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic start);
        int g;
        src_ch.valid     <= 1'b1;
        src_ch.src_byte  <= b;
        src_ch.start_req <= start;
        @(posedge clk);
        while (!src_ch.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        g = gaps_on ? pick_gap() : 0;
        if (g > 0)
        begin
            src_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // stop sending and wait until every word is back
    task automatic drain();
        src_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        drain();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.dst_capacity <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cap_writes++;
    endtask

    // one quoted literal; a broken one gets at most one fault somewhere inside
    task automatic send_literal(input int len, input bit broken);
        logic [7:0] q;
        int         fault_at;
        int         i;
        int         r;
        q = $urandom_range(0, 1) ? sle_pkg::CH_DQUOTE : sle_pkg::CH_SQUOTE;
        fault_at = broken ? $urandom_range(0, len) : -1;
        put_byte(q, 1'b1);
        for (i = 0; i < len; i++)
        begin
            if (i == fault_at)
            begin
                case ($urandom_range(0, 3))
                    0: put_byte(8'($urandom_range(0, 31)), 1'b0);
                    1: put_byte(8'($urandom_range(0, 255)), 1'b1);
                    2:
                    begin
                        put_byte(sle_pkg::CH_BSLASH, 1'b0);
                        put_byte(8'($urandom_range(0, 31)), 1'b0);
                    end
                    default: return;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                put_byte(sle_pkg::CH_BSLASH, 1'b0);
                put_byte(escape_target(q), 1'b0);
            end
            else if (r < 20)
            begin
                put_byte(sle_pkg::CH_TAB, 1'b0);
            end
            else if (r < 25)
            begin
                put_byte(other_quote(q), 1'b0);
            end
            else
            begin
                put_byte(plain_char(q), 1'b0);
            end
        end
        put_byte(q, 1'b0);
    endtask

    task automatic run_phase(input int n);
        int stop;
        int r;
        int len;
        stop = bytes_sent + n;
        while (bytes_sent < stop)
        begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            if (r < 72)
            begin
                send_literal(len, 1'b0);
            end
            else if (r < 82)
            begin
                send_literal(len, 1'b1);
            end
            else if (r < 88)
            begin
                put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (r < 97)
            begin
                put_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                drain();
            end
        end
    endtask

    // one long literal sent back to back
    task automatic send_long_literal(input int len);
        int i;
        gaps_on = 1'b0;
        put_byte(sle_pkg::CH_DQUOTE, 1'b1);
        for (i = 0; i < len; i++)
        begin
            put_byte(plain_char(sle_pkg::CH_DQUOTE), 1'b0);
        end
        put_byte(sle_pkg::CH_DQUOTE, 1'b0);
        gaps_on = 1'b1;
    endtask

    // result side: random ready bursts and stalls, plus a long hold on request
    initial
    begin : result_pacing
        int stall_left;
        int run_left;
        int hold_seen;
        stall_left = 0;
        run_left   = 0;
        hold_seen  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen  = hold_token;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                         : $urandom_range(1, 40);
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        src_ch.valid        <= 1'b0;
        src_ch.src_byte     <= 8'h00;
        src_ch.start_req    <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.dst_capacity <= sle_pkg::CAPACITY_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad opening, idle byte, escapes, escaped control, restart
        put_byte(8'h41, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(sle_pkg::CH_DQUOTE, 1'b1);
        put_byte(8'h78, 1'b0);
        put_byte(sle_pkg::CH_BSLASH, 1'b0);
        put_byte(sle_pkg::CH_N, 1'b0);
        put_byte(sle_pkg::CH_BSLASH, 1'b0);
        put_byte(sle_pkg::CH_T, 1'b0);
        put_byte(sle_pkg::CH_BSLASH, 1'b0);
        put_byte(sle_pkg::CH_R, 1'b0);
        put_byte(sle_pkg::CH_BSLASH, 1'b0);
        put_byte(sle_pkg::CH_DQUOTE, 1'b0);
        put_byte(sle_pkg::CH_BSLASH, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(sle_pkg::CH_SQUOTE, 1'b1);
        put_byte(sle_pkg::CH_TAB, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(sle_pkg::CH_DQUOTE, 1'b0);
        put_byte(sle_pkg::CH_DQUOTE, 1'b1);
        put_byte(8'h20, 1'b0);
        put_byte(sle_pkg::CH_DQUOTE, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(sle_pkg::CH_SQUOTE, 1'b1);
        put_byte(8'h1F, 1'b0);

        // capacity 1: nothing fits
        write_capacity(16'd1);
        send_literal(4, 1'b0);
        run_phase(200);

        write_capacity(16'd2);
        run_phase(200);

        // long result stall while bytes keep coming, so the input backs up
        write_capacity(16'($urandom_range(3, 20)));
        hold_token <= hold_token + 1;
        gaps_on = 1'b0;
        repeat (4) send_literal(30, 1'b0);
        gaps_on = 1'b1;
        run_phase(200);

        write_capacity(16'hFFFF);
        send_long_literal(LONG_LEN);
        run_phase(100);

        write_capacity(16'($urandom_range(1, 65535)));
        run_phase(200);

        write_capacity(16'($urandom_range(1, 8)));
        run_phase(200);

        write_capacity(sle_pkg::CAPACITY_RESET);
        run_phase(200);

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d bytes under %0d capacity settings, incl. a %0d-byte literal",
                 bytes_sent, cap_writes, LONG_LEN);
        $display("Words seen: %0d stored, %0d dropped, %0d ended, %0d failed",
                 stored_seen, dropped_seen, ended_seen, failed_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
